/* rtl/itli_pkg.sv */
// Shared types, constants and state codes for the inverse table lookup unit.
package itli_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SAMPLE_W    = 32;
	localparam int PTS_W       = 11;
	localparam int STEP_W      = 32;
	localparam int POS_W       = 48;
	localparam int FRAC_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// Datapath widths of the shared divide / multiply unit.
	localparam int DIVISOR_W   = SAMPLE_W;
	localparam int DIVIDEND_W  = SAMPLE_W + FRAC_W;
	localparam int U_W         = DIVIDEND_W + 2;
	localparam int PROD_W      = U_W + STEP_W;
	localparam int DIV_STEPS   = DIVIDEND_W;
	localparam int MUL_STEPS   = STEP_W;
	localparam int CNT_W       = $clog2(DIV_STEPS);

	localparam logic [POS_W-1:0] POS_LIMIT = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0] NEG_LIMIT = {1'b1, {(POS_W-1){1'b0}}};

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINTS = 2'd0,
		REG_STEP   = 2'd1,
		REG_ASC    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ALU_DIV = 1'b0,
		ALU_MUL = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH,
		ST_CMP,
		ST_RHI,
		ST_EVAL,
		ST_DIV,
		ST_POS,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t                        operation;
		logic [ADDR_W-1:0]          entry_index;
		logic signed [SAMPLE_W-1:0] sample_value;
	} itli_in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic                    exact_match;
		logic                    flat_segment;
		logic                    saturated;
	} itli_out_t;

	typedef struct packed {
		logic                 start;
		alu_op_t              op;
		logic [U_W-1:0]       opa;
		logic [STEP_W-1:0]    opb;
	} alu_cmd_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quo;
		logic [PROD_W-1:0]     prod;
	} alu_res_t;

endpackage

/* rtl/itli_ram.sv */
// Generic single-port RAM with registered read.
module itli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* rtl/itli_alu.sv */
// Shared shift-add / shift-subtract unit: restoring divide and serial multiply.
module itli_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  itli_pkg::alu_cmd_t  cmd,
	output itli_pkg::alu_res_t  res
);

	localparam int PW = itli_pkg::PROD_W;
	localparam int DW = itli_pkg::DIVIDEND_W;
	localparam int VW = itli_pkg::DIVISOR_W;

	logic                         busy_q;
	logic                         done_q;
	itli_pkg::alu_op_t            op_q;
	logic [itli_pkg::CNT_W-1:0]   cnt_q;
	logic [PW-1:0]                acc_q;
	logic [PW-1:0]                sh_q;
	logic [itli_pkg::STEP_W-1:0]  opb_q;

	logic [VW:0]   rem_sh;
	logic [PW-1:0] add_a;
	logic [PW-1:0] add_b;
	logic          sub;
	logic [PW-1:0] sum;
	logic          neg;

	always_comb begin
		rem_sh = {acc_q[VW-1:0], sh_q[DW-1]};
		if (op_q == itli_pkg::ALU_DIV) begin
			add_a = {{(PW-VW-1){1'b0}}, rem_sh};
			add_b = ~{{(PW-itli_pkg::STEP_W){1'b0}}, opb_q};
			sub   = 1'b1;
		end else begin
			add_a = acc_q;
			add_b = opb_q[0] ? sh_q : '0;
			sub   = 1'b0;
		end
		sum = add_a + add_b + {{(PW-1){1'b0}}, sub};
		neg = sum[PW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= itli_pkg::ALU_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= (cmd.op == itli_pkg::ALU_DIV) ?
					itli_pkg::CNT_W'(itli_pkg::DIV_STEPS - 1) :
					itli_pkg::CNT_W'(itli_pkg::MUL_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			sh_q  <= {{(PW-itli_pkg::U_W){1'b0}}, cmd.opa};
			opb_q <= cmd.opb;
		end else if (busy_q) begin
			if (op_q == itli_pkg::ALU_DIV) begin
				// trial subtract, keep the partial remainder on borrow
				acc_q <= neg ? {{(PW-VW-1){1'b0}}, rem_sh} : sum;
				sh_q  <= {sh_q[PW-2:0], ~neg};
			end else begin
				acc_q <= sum;
				sh_q  <= {sh_q[PW-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[itli_pkg::STEP_W-1:1]};
			end
		end
	end

	assign res.done = done_q;
	assign res.quo  = sh_q[DW-1:0];
	assign res.prod = acc_q;

endmodule

/* rtl/inverse_table_lookup_interp_unit.sv */
// Inverse table lookup: binary search, linear interpolation, step scaling.
// Load word: written to the table at acceptance, no result word.
// Query word: one search halving per pass through the search and compare states (at most 10
// halvings for 1024 entries), the end reads and evaluation, a serial divide when interpolating,
// the start of the multiply, a serial multiply by the step, then the load of the result register;
// no new word is taken before that load. Reset clears control and configuration only.
module inverse_table_lookup_interp_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  itli_pkg::itli_in_t                   req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output itli_pkg::itli_out_t                  rsp,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [itli_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [itli_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = itli_pkg::ADDR_W;
	localparam int SW = itli_pkg::SAMPLE_W;
	localparam int UW = itli_pkg::U_W;
	localparam int FW = itli_pkg::FRAC_W;
	localparam int PW = itli_pkg::PROD_W;
	localparam int QW = itli_pkg::POS_W;

	itli_pkg::state_t state_q, state_d;

	// configuration
	logic [itli_pkg::PTS_W-1:0]  points_q;
	logic [itli_pkg::STEP_W-1:0] step_q;
	logic                        asc_q;

	// search / datapath
	logic signed [SW-1:0] v_q;
	logic signed [SW-1:0] flo_q;
	logic [AW-1:0]        lo_q, hi_q, mid_q;
	logic                 exact_q, flat_q, qneg_q, neg_q;
	logic signed [UW-1:0] u16_q;

	// output register
	logic                 rsp_valid_q;
	itli_pkg::itli_out_t  rsp_q;

	logic                 req_acc;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [SW-1:0]        ram_rdata;
	logic signed [SW-1:0] fm;

	logic [AW:0]          mid_sum;
	logic [AW-1:0]        mid;
	logic                 go_on;
	logic [AW-1:0]        hi_init;
	logic                 below, above;

	logic signed [SW:0]   num, den;
	logic [SW:0]          num_mag, den_mag;
	logic                 hit_lo, hit_hi, flat_pair;

	logic signed [UW-1:0] q_signed;
	logic [UW-1:0]        mag;

	logic [PW-FW-1:0]     p_full;
	logic [QW-1:0]        limit;
	logic                 over;
	logic [QW-1:0]        p_sat;
	logic                 out_free;

	itli_pkg::alu_cmd_t   alu_cmd;
	itli_pkg::alu_res_t   alu_res;

	itli_ram #(
		.WIDTH (SW),
		.DEPTH (itli_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (req.sample_value),
		.rdata (ram_rdata)
	);

	itli_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.res    (alu_res)
	);

	assign fm        = signed'(ram_rdata);
	assign req_stall = (state_q != itli_pkg::ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// search arithmetic
	always_comb begin
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid     = mid_sum[AW:1];
		go_on   = ({1'b0, lo_q} + (AW+1)'(1)) < {1'b0, hi_q};
		if (points_q < itli_pkg::PTS_W'(2)) begin
			hi_init = AW'(1);
		end else if (points_q > itli_pkg::PTS_W'(itli_pkg::TABLE_DEPTH)) begin
			hi_init = AW'(itli_pkg::TABLE_DEPTH - 1);
		end else begin
			hi_init = AW'(points_q - itli_pkg::PTS_W'(1));
		end
		below = asc_q ? (v_q < fm) : (v_q > fm);
		above = asc_q ? (v_q > fm) : (v_q < fm);
	end

	// end-pair evaluation, fm holds the upper entry here
	always_comb begin
		num       = {v_q[SW-1], v_q} - {flo_q[SW-1], flo_q};
		den       = {fm[SW-1], fm} - {flo_q[SW-1], flo_q};
		num_mag   = num[SW] ? -num : num;
		den_mag   = den[SW] ? -den : den;
		hit_lo    = (v_q == flo_q);
		hit_hi    = (v_q == fm);
		flat_pair = (flo_q == fm);
	end

	always_comb begin
		q_signed = qneg_q ? -signed'({{(UW-itli_pkg::DIVIDEND_W){1'b0}}, alu_res.quo}) :
			signed'({{(UW-itli_pkg::DIVIDEND_W){1'b0}}, alu_res.quo});
		mag      = u16_q[UW-1] ? UW'(-u16_q) : UW'(u16_q);
	end

	// scaling and saturation of the finished product
	always_comb begin
		p_full = alu_res.prod[PW-1:FW];
		limit  = neg_q ? itli_pkg::NEG_LIMIT : itli_pkg::POS_LIMIT;
		over   = p_full > {{(PW-FW-QW){1'b0}}, limit};
		p_sat  = over ? limit : p_full[QW-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itli_pkg::ST_IDLE: begin
				if (req_acc && req.operation == itli_pkg::OP_QUERY) begin
					state_d = itli_pkg::ST_SRCH;
				end
			end
			itli_pkg::ST_SRCH: state_d = go_on ? itli_pkg::ST_CMP : itli_pkg::ST_RHI;
			itli_pkg::ST_CMP: begin
				state_d = (below || above) ? itli_pkg::ST_SRCH : itli_pkg::ST_POS;
			end
			itli_pkg::ST_RHI: state_d = itli_pkg::ST_EVAL;
			itli_pkg::ST_EVAL: begin
				state_d = (hit_lo || hit_hi || flat_pair) ? itli_pkg::ST_POS : itli_pkg::ST_DIV;
			end
			itli_pkg::ST_DIV: begin
				if (alu_res.done) begin
					state_d = itli_pkg::ST_POS;
				end
			end
			itli_pkg::ST_POS: state_d = itli_pkg::ST_MUL;
			itli_pkg::ST_MUL: begin
				if (alu_res.done) begin
					state_d = itli_pkg::ST_OUT;
				end
			end
			itli_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = itli_pkg::ST_IDLE;
				end
			end
			default: state_d = itli_pkg::ST_IDLE;
		endcase
	end

	// outputs: table port and shared unit commands
	always_comb begin
		ram_we        = 1'b0;
		ram_addr      = lo_q;
		alu_cmd.start = 1'b0;
		alu_cmd.op    = itli_pkg::ALU_DIV;
		alu_cmd.opa   = {{(UW-itli_pkg::DIVIDEND_W){1'b0}}, num_mag[SW-1:0], {FW{1'b0}}};
		alu_cmd.opb   = den_mag[SW-1:0];
		unique case (state_q)
			itli_pkg::ST_IDLE: begin
				ram_addr = req.entry_index;
				ram_we   = req_acc && req.operation == itli_pkg::OP_LOAD &&
					({1'b0, req.entry_index} < (AW+1)'(itli_pkg::TABLE_DEPTH));
			end
			itli_pkg::ST_SRCH: ram_addr = go_on ? mid : lo_q;
			itli_pkg::ST_RHI:  ram_addr = hi_q;
			itli_pkg::ST_EVAL: alu_cmd.start = !(hit_lo || hit_hi || flat_pair);
			itli_pkg::ST_POS: begin
				alu_cmd.start = 1'b1;
				alu_cmd.op    = itli_pkg::ALU_MUL;
				alu_cmd.opa   = mag;
				alu_cmd.opb   = step_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itli_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
			points_q    <= itli_pkg::PTS_W'(itli_pkg::TABLE_DEPTH);
			step_q      <= itli_pkg::STEP_W'(65536);
			asc_q       <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == itli_pkg::ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (itli_pkg::cfg_reg_t'(cfg_index))
					itli_pkg::REG_POINTS: points_q <= cfg_data[itli_pkg::PTS_W-1:0];
					itli_pkg::REG_STEP:   step_q   <= cfg_data[itli_pkg::STEP_W-1:0];
					itli_pkg::REG_ASC:    asc_q    <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			itli_pkg::ST_IDLE: begin
				v_q     <= req.sample_value;
				lo_q    <= '0;
				hi_q    <= hi_init;
				exact_q <= 1'b0;
				flat_q  <= 1'b0;
			end
			itli_pkg::ST_SRCH: mid_q <= mid;
			itli_pkg::ST_CMP: begin
				if (below) begin
					hi_q <= mid_q;
				end else if (above) begin
					lo_q <= mid_q;
				end else begin
					exact_q <= 1'b1;
					u16_q   <= signed'({{(UW-AW-FW){1'b0}}, mid_q, {FW{1'b0}}});
				end
			end
			itli_pkg::ST_RHI: flo_q <= fm;
			itli_pkg::ST_EVAL: begin
				qneg_q <= num[SW] ^ den[SW];
				if (hit_lo) begin
					exact_q <= 1'b1;
					u16_q   <= signed'({{(UW-AW-FW){1'b0}}, lo_q, {FW{1'b0}}});
				end else if (hit_hi) begin
					exact_q <= 1'b1;
					u16_q   <= signed'({{(UW-AW-FW){1'b0}}, hi_q, {FW{1'b0}}});
				end else if (flat_pair) begin
					flat_q <= 1'b1;
					u16_q  <= signed'({{(UW-AW-FW){1'b0}}, lo_q, {FW{1'b0}}});
				end
			end
			itli_pkg::ST_DIV: begin
				if (alu_res.done) begin
					u16_q <= signed'({{(UW-AW-FW){1'b0}}, lo_q, {FW{1'b0}}}) + q_signed;
				end
			end
			itli_pkg::ST_POS: neg_q <= u16_q[UW-1];
			itli_pkg::ST_OUT: begin
				if (out_free) begin
					rsp_q.position     <= neg_q ? signed'(-p_sat) : signed'(p_sat);
					rsp_q.exact_match  <= exact_q;
					rsp_q.flat_segment <= flat_q;
					rsp_q.saturated    <= over;
				end
			end
			default: ;
		endcase
	end

endmodule
